>>> sv/rv32a_pkg.sv
// ----------------------------------------------------------------------------
// rv32a_pkg
// shared types and constants of the rv32a atomic unit
// ----------------------------------------------------------------------------
package rv32a_pkg;

  localparam logic [6:0] OPC_AMO  = 7'b01_011_11;
  localparam logic [2:0] F3_WORD  = 3'h2;

  localparam logic [4:0] F5_LR    = 5'b000_10;
  localparam logic [4:0] F5_SC    = 5'b000_11;
  localparam logic [4:0] F5_SWAP  = 5'b000_01;
  localparam logic [4:0] F5_ADD   = 5'b000_00;
  localparam logic [4:0] F5_XOR   = 5'b001_00;
  localparam logic [4:0] F5_AND   = 5'b011_00;
  localparam logic [4:0] F5_OR    = 5'b010_00;
  localparam logic [4:0] F5_MIN   = 5'b100_00;
  localparam logic [4:0] F5_MAX   = 5'b101_00;
  localparam logic [4:0] F5_MINU  = 5'b110_00;
  localparam logic [4:0] F5_MAXU  = 5'b111_00;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNSUP     = 2'd1;
  localparam logic [1:0] ST_UNALIGNED = 2'd2;
  localparam logic [1:0] ST_RDERR     = 2'd3;

  localparam logic [31:0] SC_SUCCESS  = 32'd0;
  localparam logic [31:0] SC_NO_RSV   = 32'd1;
  localparam logic [31:0] SC_CHANGED  = 32'd2;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [4:0]  funct5;
    logic [31:0] address;
    logic [31:0] operand_value;
    logic [31:0] read_data;
    logic        read_error;
    logic [1:0]  snoop_offset;
    logic [2:0]  snoop_length;
    logic [31:0] snoop_data;
  } rv32a_in_t;

  typedef struct packed {
    logic        rd_write;
    logic [31:0] rd_value;
    logic        mem_write;
    logic [31:0] mem_write_data;
    logic [1:0]  status;
  } rv32a_out_t;

  typedef struct packed {
    logic        lr_en;
    logic        sc_en;
    logic        snoop_en;
    logic [31:0] address;
    logic [31:0] lr_data;
    logic [1:0]  snoop_offset;
    logic [2:0]  snoop_length;
    logic [31:0] snoop_data;
  } rv32a_rsv_req_t;

  typedef struct packed {
    logic hit;
    logic changed;
  } rv32a_rsv_resp_t;

endpackage

>>> sv/rv32a_atomic_unit_core.sv
// ----------------------------------------------------------------------------
// rv32a_atomic_unit_core
// rv32a word atomic execution unit with an lr reservation table
// ----------------------------------------------------------------------------
// each item passes through the item register and then the result register
// throughput: one item per cycle unless output backpressure stalls a result; a snoop produces no result
// the item register and the result register stall only on output backpressure
// reset clears the reservation valid bits, the replace pointer and both valids
// ----------------------------------------------------------------------------
module rv32a_atomic_unit_core #(
  parameter int RESERVATION_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rv32a_pkg::rv32a_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rv32a_pkg::rv32a_out_t out_data
);
  import rv32a_pkg::*;

  logic            stage_valid;
  rv32a_in_t       stage;
  logic            stage_go;
  logic            legal;
  logic            aligned;
  logic            is_lr;
  logic            is_sc;
  logic            is_amo;
  logic [31:0]     alu_result;
  rv32a_out_t      result;
  rv32a_rsv_req_t  rsv_req;
  rv32a_rsv_resp_t rsv_resp;

  assign stage_go = stage_valid && (stage.cmd || !out_valid || out_ready);
  assign in_ready = !stage_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  rv32a_alu u_alu (
    .funct5        (stage.funct5),
    .read_data     (stage.read_data),
    .operand_value (stage.operand_value),
    .result        (alu_result),
    .is_amo        (is_amo)
  );

  assign is_lr   = stage.funct5 == F5_LR;
  assign is_sc   = stage.funct5 == F5_SC;
  assign legal   = stage.opcode == OPC_AMO && stage.funct3 == F3_WORD &&
                   (is_amo || is_lr || is_sc);
  assign aligned = stage.address[1:0] == 2'b00;

  always_comb begin
    rsv_req.lr_en        = stage_go && !stage.cmd && legal && aligned && is_lr &&
                           !stage.read_error;
    rsv_req.sc_en        = stage_go && !stage.cmd && legal && aligned && is_sc;
    rsv_req.snoop_en     = stage_go && stage.cmd;
    rsv_req.address      = stage.address;
    rsv_req.lr_data      = stage.read_data;
    rsv_req.snoop_offset = stage.snoop_offset;
    rsv_req.snoop_length = stage.snoop_length;
    rsv_req.snoop_data   = stage.snoop_data;
  end

  rv32a_rsv #(
    .SLOTS (RESERVATION_SLOTS)
  ) u_rsv (
    .clk  (clk),
    .rst  (rst),
    .req  (rsv_req),
    .resp (rsv_resp)
  );

  always_comb begin
    result = '0;
    priority if (!legal) begin
      result.status = ST_UNSUP;
    end else if (!aligned) begin
      result.status = ST_UNALIGNED;
    end else if (is_sc) begin
      result.rd_write = 1'b1;
      priority if (!rsv_resp.hit) begin
        result.rd_value = SC_NO_RSV;
      end else if (rsv_resp.changed) begin
        result.rd_value = SC_CHANGED;
      end else begin
        result.rd_value       = SC_SUCCESS;
        result.mem_write      = 1'b1;
        result.mem_write_data = stage.operand_value;
      end
    end else if (stage.read_error) begin
      result.status = ST_RDERR;
    end else if (is_lr) begin
      result.rd_write = 1'b1;
      result.rd_value = stage.read_data;
    end else begin
      result.rd_write       = 1'b1;
      result.rd_value       = stage.read_data;
      result.mem_write      = 1'b1;
      result.mem_write_data = alu_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && !stage.cmd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && !stage.cmd) begin
      out_data <= result;
    end
  end

endmodule

>>> sv/rv32a_alu.sv
// ----------------------------------------------------------------------------
// rv32a_alu
// combines the old memory word with the operand for the amo operations
// ----------------------------------------------------------------------------
module rv32a_alu (
  input  logic [4:0]  funct5,
  input  logic [31:0] read_data,
  input  logic [31:0] operand_value,
  output logic [31:0] result,
  output logic        is_amo
);
  import rv32a_pkg::*;

  logic s_lt_op;
  logic s_lt_rd;
  logic u_lt_op;
  logic u_lt_rd;

  assign s_lt_op = $signed(operand_value) < $signed(read_data);
  assign s_lt_rd = $signed(read_data) < $signed(operand_value);
  assign u_lt_op = operand_value < read_data;
  assign u_lt_rd = read_data < operand_value;

  always_comb begin
    is_amo = 1'b1;
    unique case (funct5)
      F5_SWAP: result = operand_value;
      F5_ADD:  result = read_data + operand_value;
      F5_XOR:  result = read_data ^ operand_value;
      F5_AND:  result = read_data & operand_value;
      F5_OR:   result = read_data | operand_value;
      F5_MIN:  result = s_lt_op ? operand_value : read_data;
      F5_MAX:  result = s_lt_rd ? operand_value : read_data;
      F5_MINU: result = u_lt_op ? operand_value : read_data;
      F5_MAXU: result = u_lt_rd ? operand_value : read_data;
      default: begin
        is_amo = 1'b0;
        result = 32'd0;
      end
    endcase
  end

endmodule

>>> sv/rv32a_rsv.sv
// ----------------------------------------------------------------------------
// rv32a_rsv
// reservation table: parallel address match, lr allocation, sc release and
// snoop byte merge
// ----------------------------------------------------------------------------
module rv32a_rsv #(
  parameter int SLOTS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rv32a_pkg::rv32a_rsv_req_t  req,
  output rv32a_pkg::rv32a_rsv_resp_t resp
);
  import rv32a_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [SLOTS-1:0] slot_valid;
  logic [31:0]      slot_address [SLOTS];
  logic [31:0]      slot_value   [SLOTS];
  logic [SLOTS-1:0] slot_changed;
  logic [IDX_W-1:0] replace_pointer;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] lr_idx;
  logic [31:0]      old_value;
  logic [31:0]      merged_value;
  logic [31:0]      byte_mask;
  logic [31:0]      shifted_data;
  logic             snoop_fits;
  logic             snoop_upd;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_address[i] == req.address) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      lr_idx = hit_idx;
    end else if (free_found) begin
      lr_idx = free_idx;
    end else begin
      lr_idx = replace_pointer;
    end
  end

  // snoop byte merge
  assign snoop_fits   = {1'b0, req.snoop_length} <= (4'd4 - {2'b00, req.snoop_offset});
  assign old_value    = slot_value[hit_idx];
  assign shifted_data = req.snoop_data << {req.snoop_offset, 3'b000};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_mask[k*8 +: 8] =
        (3'(k) >= {1'b0, req.snoop_offset} &&
         4'(k) < ({2'b00, req.snoop_offset} + {1'b0, req.snoop_length})) ? 8'hff : 8'h00;
    end
  end

  assign merged_value = (old_value & ~byte_mask) | (shifted_data & byte_mask);
  assign snoop_upd    = req.snoop_en && hit && snoop_fits && merged_value != old_value;

  assign resp.hit     = hit;
  assign resp.changed = slot_changed[hit_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      replace_pointer <= '0;
    end else begin
      if (req.lr_en) begin
        slot_valid[lr_idx] <= 1'b1;
        if (!hit && !free_found) begin
          replace_pointer <= (replace_pointer == LAST_IDX) ? '0 : replace_pointer + 1'b1;
        end
      end else if (req.sc_en && hit) begin
        slot_valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.lr_en) begin
      slot_address[lr_idx] <= req.address;
      slot_value[lr_idx]   <= req.lr_data;
      slot_changed[lr_idx] <= 1'b0;
    end else if (snoop_upd) begin
      slot_value[hit_idx]   <= merged_value;
      slot_changed[hit_idx] <= 1'b1;
    end
  end

endmodule
